>>> sv/slrg_pkg.sv
// slrg_pkg: shared types and constants of the shuffled lehmer random generator
// used by slrg_ctrl, slrg_datapath and the top level; no dependencies
package slrg_pkg;

  // word width of the lehmer recurrence and the table entries
  localparam int unsigned WORD_W = 31;

  // park-miller minimal standard constants
  localparam logic [14:0]       LEHMER_MUL = 15'd16807;
  localparam logic [WORD_W-1:0] LEHMER_MOD = 31'd2147483647;

  // sample from which a fraction would be clamped to 1 - 1.2e-7
  localparam logic [WORD_W-1:0] CLAMP_FROM = 31'd2147483390;

  // seed register value after reset
  localparam logic [31:0] SEED_RESET = 32'd65248;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_seed;  // load running value from the seed rule
    logic mul;        // register both products for one step
    logic su_red;     // start-up step: reduce and update running value
    logic su_wr;      // start-up step also fills a table slot
    logic su_last;    // final start-up step: result becomes last pick
    logic red;        // normal step: reduce, pick slot, read table
    logic wrb;        // normal step: write back, load output register
  } slrg_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic lp_zero;    // last pick is zero, generator not started
    logic out_stall;  // output register holds a transaction not yet taken
  } slrg_sts_t;

endpackage

>>> sv/slrg_ctrl.sv
// slrg_ctrl: request sequencer of the shuffled lehmer random generator
// runs start-up (seed, warm-up, table fill) and the normal step; uses slrg_pkg
module slrg_ctrl #(
  parameter int unsigned TABLE_DEPTH  = 32,
  parameter int unsigned WARMUP_STEPS = 8,
  parameter int unsigned IW           = $clog2(TABLE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic                  req_reseed,
  input  slrg_pkg::slrg_sts_t   sts,
  output slrg_pkg::slrg_cmd_t   cmd,
  output logic [IW-1:0]         fill_idx
);
  import slrg_pkg::*;

  localparam int unsigned STEPS = TABLE_DEPTH + WARMUP_STEPS;
  localparam int unsigned CW    = $clog2(STEPS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SEED = 3'd1;
  localparam logic [2:0] ST_SMUL = 3'd2;
  localparam logic [2:0] ST_SRED = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_RED  = 3'd5;
  localparam logic [2:0] ST_WRB  = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign req_ready = (state_r == ST_IDLE);
  assign fill_idx  = cnt_r[IW-1:0];

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.su_wr   = (cnt_r < CW'(TABLE_DEPTH));
    cmd.su_last = (cnt_r == '0);
    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          state_nxt = (req_reseed || sts.lp_zero) ? ST_SEED : ST_MUL;
        end
      end
      ST_SEED: begin
        cmd.load_seed = 1'b1;
        cnt_nxt       = CW'(STEPS - 1);
        state_nxt     = ST_SMUL;
      end
      ST_SMUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SRED;
      end
      ST_SRED: begin
        cmd.su_red = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_MUL;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = ST_SMUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_RED;
      end
      ST_RED: begin
        cmd.red   = 1'b1;
        state_nxt = ST_WRB;
      end
      ST_WRB: begin
        if (!sts.out_stall) begin
          cmd.wrb   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // at most one datapath action per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_seed, cmd.mul, cmd.su_red, cmd.red, cmd.wrb}))
    else $error("slrg_ctrl: more than one datapath command");

  // write-back never overwrites a pending output transaction
  a_wrb_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wrb |-> !sts.out_stall)
    else $error("slrg_ctrl: write-back while output stalled");

endmodule

>>> sv/slrg_datapath.sv
// slrg_datapath: lehmer step, slot pick, shuffle table and output register
// driven by slrg_ctrl commands; uses slrg_pkg
module slrg_datapath #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned IW          = $clog2(TABLE_DEPTH)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [31:0]                      cfg_seed,
  input  slrg_pkg::slrg_cmd_t              cmd,
  input  logic [IW-1:0]                    fill_idx,
  output slrg_pkg::slrg_sts_t              sts,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [slrg_pkg::WORD_W-1:0]      out_sample,
  output logic                             out_clamped
);
  import slrg_pkg::*;

  // slot divisor and its reciprocal scaled by 2^31
  localparam longint SLOT_DIV = 1 + 64'd2147483646 / TABLE_DEPTH;
  localparam longint RECIP    = (64'd1 << 31) / SLOT_DIV;
  localparam int unsigned RW  = $clog2(RECIP + 1);
  localparam logic [WORD_W-1:0] SLOT_DIV_C = WORD_W'(SLOT_DIV);
  localparam logic [RW-1:0]     RECIP_C    = RW'(RECIP);
  localparam logic [RW:0]       TOP_SLOT   = (RW + 1)'(TABLE_DEPTH - 1);

  logic [31:0]          seed_r;
  logic [WORD_W-1:0]    rv_r;
  logic [WORD_W-1:0]    last_pick_r;
  logic [WORD_W+14:0]   prod_r;
  logic [WORD_W+RW-1:0] sprod_r;
  logic [IW-1:0]        slot_r;
  logic [WORD_W-1:0]    rd_r;
  logic                 out_valid_r;
  logic [WORD_W-1:0]    out_sample_r;
  logic                 out_clamped_r;
  logic [WORD_W-1:0]    tbl [TABLE_DEPTH];

  logic [31:0]       mag;
  logic [WORD_W-1:0] seed_start;
  logic [31:0]       fold;
  logic [WORD_W-1:0] red;
  logic [RW-1:0]     q_est;
  logic [WORD_W-1:0] q_rem;
  logic [RW:0]       q_full;
  logic [IW-1:0]     slot;

  // seed rule: magnitude of a negative seed mod the modulus, else 1
  always_comb begin
    mag = 32'(-seed_r);
    if (!seed_r[31]) begin
      seed_start = WORD_W'(1);
    end else if (mag >= {1'b0, LEHMER_MOD}) begin
      seed_start = WORD_W'(mag - {1'b0, LEHMER_MOD});
    end else begin
      seed_start = mag[WORD_W-1:0];
    end
  end

  // mersenne reduction of the registered product
  always_comb begin
    fold = 32'(prod_r[WORD_W+14:WORD_W]) + {1'b0, prod_r[WORD_W-1:0]};
    if (fold >= {1'b0, LEHMER_MOD}) begin
      red = WORD_W'(fold - {1'b0, LEHMER_MOD});
    end else begin
      red = fold[WORD_W-1:0];
    end
  end

  // slot = last pick / slot divisor, reciprocal estimate plus one correction, capped at the top slot
  always_comb begin
    q_est  = sprod_r[WORD_W +: RW];
    q_rem  = last_pick_r - WORD_W'(q_est * SLOT_DIV_C);
    q_full = {1'b0, q_est} + (RW + 1)'(q_rem >= SLOT_DIV_C);
    if (q_full > TOP_SLOT) begin
      slot = TOP_SLOT[IW-1:0];
    end else begin
      slot = q_full[IW-1:0];
    end
  end

  // seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (cfg_we) begin
      seed_r <= cfg_seed;
    end
  end

  // running value and last pick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r        <= WORD_W'(1);
      last_pick_r <= '0;
    end else begin
      if (cmd.load_seed) begin
        rv_r <= seed_start;
      end else if (cmd.su_red || cmd.red) begin
        rv_r <= red;
      end
      if (cmd.su_red && cmd.su_last) begin
        last_pick_r <= red;
      end else if (cmd.wrb) begin
        last_pick_r <= rd_r;
      end
    end
  end

  // product registers of one step
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r  <= rv_r * LEHMER_MUL;
      sprod_r <= last_pick_r * RECIP_C;
    end
  end

  // shuffle table: one write port, registered read
  always_ff @(posedge clk) begin
    if (cmd.su_red && cmd.su_wr) begin
      tbl[fill_idx] <= red;
    end else if (cmd.wrb) begin
      tbl[slot_r] <= rv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.red) begin
      slot_r <= slot;
      rd_r   <= tbl[slot];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.wrb) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wrb) begin
      out_sample_r  <= rd_r;
      out_clamped_r <= (rd_r >= CLAMP_FROM);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_clamped   = out_clamped_r;
  assign sts.lp_zero   = (last_pick_r == '0);
  assign sts.out_stall = out_valid_r && !out_ready;

  // picked slot stays inside the table
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.red |=> ({1'b0, slot_r} <= (IW + 1)'(TABLE_DEPTH - 1)))
    else $error("slrg_datapath: slot out of range");

  // reduction never leaves the modulus itself
  a_rv_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    rv_r != LEHMER_MOD)
    else $error("slrg_datapath: running value not reduced");

  // every write-back presents a transaction next cycle
  a_wrb_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wrb |=> out_valid_r)
    else $error("slrg_datapath: write-back lost");

endmodule

>>> sv/shuffled_lehmer_random_generator.sv
// shuffled_lehmer_random_generator: park-miller generator behind a shuffle table
// top level joining slrg_ctrl and slrg_datapath; uses slrg_pkg
//
//   channel | direction | handshake            | payload
//   in_     | slave     | in_tvalid/in_tready   | in_tdata[0] reseed
//   out_    | master    | out_tvalid/out_tready | out_tdata[30:0] sample, out_tuser clamped
//   cfg_    | slave     | cfg_valid/cfg_ready   | cfg_data seed (signed)
//
// a normal request passes through accept in idle, product, reduce with table
// read and write-back; the sample is loaded into the output register at write-back.
// start-up (first request after reset, reseed set, or last pick zero) adds a
// seed load and a product and reduce state per lehmer step, TABLE_DEPTH +
// WARMUP_STEPS steps; the last TABLE_DEPTH fill the table via its single write port.
// reset is synchronous, active low; the table needs no clearing pass.
// write-back waits while the output register holds an untaken transaction.
module shuffled_lehmer_random_generator #(
  parameter int unsigned TABLE_DEPTH  = 32,
  parameter int unsigned WARMUP_STEPS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [0] reseed, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [30:0] sample, [31] zero
  output logic [0:0]  out_tuser,   // [0] clamped
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data     // seed
);
  import slrg_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);

  slrg_cmd_t         cmd;
  slrg_sts_t         sts;
  logic [IW-1:0]     fill_idx;
  logic [WORD_W-1:0] sample;
  logic              clamped;

  // seed writes are always taken
  assign cfg_ready = 1'b1;

  slrg_ctrl #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .WARMUP_STEPS (WARMUP_STEPS),
    .IW           (IW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_reseed (in_tdata[0]),
    .sts        (sts),
    .cmd        (cmd),
    .fill_idx   (fill_idx)
  );

  slrg_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IW          (IW)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid),
    .cfg_seed    (cfg_data),
    .cmd         (cmd),
    .fill_idx    (fill_idx),
    .sts         (sts),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_sample  (sample),
    .out_clamped (clamped)
  );

  // pack result transaction
  assign out_tdata = {1'b0, sample};
  assign out_tuser = clamped;

endmodule
